[hw/rtl/coverage_hitcount_map_assert.svh]
// ----------------------------------------------------------------------------
// Coverage hit-count map assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COVERAGE_HITCOUNT_MAP_ASSERT_SVH
`define COVERAGE_HITCOUNT_MAP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("coverage_hitcount_map: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("coverage_hitcount_map: next-cycle check failed");

`endif

[hw/rtl/chm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage hit-count map package
// Word types, queue entry type and state encodings shared by the block.
// ----------------------------------------------------------------------------
package chm_pkg;

	// Widest table address over the whole parameter range.
	localparam int ADDR_MAX_W = 24;

	localparam logic [7:0] COUNT_MAX = 8'hff;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [1:0] CFG_MAP_ENABLED = 2'd0;
	localparam logic [1:0] CFG_MAP_PAGES   = 2'd1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] edge_id;
		logic [15:0] read_index;
	} in_word_t;

	typedef struct packed {
		logic [15:0] cell_index;
		logic [7:0]  hit_count;
		logic        was_saturated;
		logic        ignored;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_RECORD,
		OP_READ,
		OP_READ_ZERO,
		OP_IGNORE
	} op_kind_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [ADDR_MAX_W-1:0]   addr;
		logic [15:0]             idx;
	} op_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

endpackage

[hw/rtl/chm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage hit-count map front end
// Accepts words, classifies them and reduces record edges modulo the map size.
// ----------------------------------------------------------------------------
module chm_front #(
	parameter int MAX_PAGES   = 16,
	parameter int PAGE_BYTES  = 4096,
	parameter int TABLE_CELLS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  chm_pkg::in_word_t in_data,
	input  logic              map_enabled,
	input  logic [4:0]        map_pages,
	input  logic              init_done,
	output logic              push_valid,
	input  logic              push_ready,
	output chm_pkg::op_t      push_data
);
	localparam int SW = $clog2(TABLE_CELLS + 1);
	localparam int PW = $clog2(MAX_PAGES + 1);

	chm_pkg::fe_state_t state_q, state_nx;
	chm_pkg::op_t       ent_q;
	logic [63:0]        edge_q;
	logic [SW-1:0]      rem_q;
	logic [SW-1:0]      div_q;
	logic [5:0]         bit_q;
	logic [PW-1:0]      pages_eff;
	logic [SW:0]        rem_sh;
	logic [SW-1:0]      rem_nx;
	logic               accept;

	always_comb begin
		if (map_pages == 5'd0) begin
			pages_eff = PW'(1);
		end else if (32'(map_pages) > MAX_PAGES) begin
			pages_eff = PW'(MAX_PAGES);
		end else begin
			pages_eff = PW'(map_pages);
		end
	end

	// One quotient bit per cycle of restoring remainder.
	always_comb begin
		rem_sh = {rem_q, edge_q[63]};
		if (rem_sh >= {1'b0, div_q}) begin
			rem_nx = SW'(rem_sh - {1'b0, div_q});
		end else begin
			rem_nx = SW'(rem_sh);
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			chm_pkg::FE_IDLE: begin
				if (in_valid && init_done) begin
					if (in_data.cmd == chm_pkg::CMD_READ || !map_enabled) begin
						state_nx = chm_pkg::FE_PUSH;
					end else begin
						state_nx = chm_pkg::FE_DIV;
					end
				end
			end
			chm_pkg::FE_DIV: begin
				if (bit_q == 6'd0) begin
					state_nx = chm_pkg::FE_PUSH;
				end
			end
			chm_pkg::FE_PUSH: begin
				if (push_ready) begin
					state_nx = chm_pkg::FE_IDLE;
				end
			end
			default: state_nx = chm_pkg::FE_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == chm_pkg::FE_IDLE) && init_done;
		push_valid = (state_q == chm_pkg::FE_PUSH);
		push_data  = ent_q;
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chm_pkg::FE_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edge_q <= in_data.edge_id;
			rem_q  <= '0;
			div_q  <= SW'(pages_eff * PAGE_BYTES);
			bit_q  <= 6'd63;
			if (in_data.cmd == chm_pkg::CMD_READ) begin
				ent_q.idx  <= in_data.read_index;
				ent_q.addr <= chm_pkg::ADDR_MAX_W'(in_data.read_index);
				if (32'(in_data.read_index) >= TABLE_CELLS) begin
					ent_q.kind <= chm_pkg::OP_READ_ZERO;
				end else begin
					ent_q.kind <= chm_pkg::OP_READ;
				end
			end else if (!map_enabled) begin
				ent_q.kind <= chm_pkg::OP_IGNORE;
				ent_q.idx  <= '0;
				ent_q.addr <= '0;
			end else begin
				ent_q.kind <= chm_pkg::OP_RECORD;
			end
		end else if (state_q == chm_pkg::FE_DIV) begin
			rem_q  <= rem_nx;
			edge_q <= {edge_q[62:0], 1'b0};
			bit_q  <= bit_q - 6'd1;
			if (bit_q == 6'd0) begin
				ent_q.addr <= chm_pkg::ADDR_MAX_W'(rem_nx);
				ent_q.idx  <= 16'(rem_nx);
			end
		end
	end

endmodule

[hw/rtl/chm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage hit-count map operation queue
// Two-entry queue that decouples the front end from the counter memory.
// ----------------------------------------------------------------------------
module chm_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  chm_pkg::op_t wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output chm_pkg::op_t rd_data
);
	chm_pkg::op_t slot_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   count_q;
	logic         do_wr;
	logic         do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slot_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= ~wptr_q;
			end
			if (do_rd) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

endmodule

[hw/rtl/chm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage hit-count map back end
// Owns the counter memory: clears it after reset and runs read-modify-writes.
// ----------------------------------------------------------------------------
module chm_back #(
	parameter int TABLE_CELLS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  chm_pkg::op_t       op_data,
	output logic               out_valid,
	input  logic               out_ready,
	output chm_pkg::out_word_t out_data,
	output logic               init_done
);
	localparam int AW = (TABLE_CELLS > 1) ? $clog2(TABLE_CELLS) : 1;

	chm_pkg::bk_state_t state_q, state_nx;
	logic [AW-1:0]      clr_q;
	chm_pkg::op_t       op_s1;
	logic [7:0]         rdata_s1;
	logic [7:0]         mem [TABLE_CELLS];
	logic [AW-1:0]      mem_addr;
	logic               mem_we;
	logic [7:0]         mem_wd;
	logic               out_valid_q;
	chm_pkg::out_word_t out_q;
	chm_pkg::out_word_t res;
	logic               out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			chm_pkg::BK_CLEAR: begin
				if (clr_q == AW'(TABLE_CELLS - 1)) begin
					state_nx = chm_pkg::BK_IDLE;
				end
			end
			chm_pkg::BK_IDLE: begin
				if (op_valid && out_free) begin
					state_nx = chm_pkg::BK_EXEC;
				end
			end
			chm_pkg::BK_EXEC: state_nx = chm_pkg::BK_IDLE;
			default:          state_nx = chm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		op_ready  = (state_q == chm_pkg::BK_IDLE) && out_free;
		init_done = (state_q != chm_pkg::BK_CLEAR);
		res       = '0;
		res.cell_index = op_s1.idx;
		case (op_s1.kind)
			chm_pkg::OP_READ: res.hit_count = rdata_s1;
			chm_pkg::OP_READ_ZERO: res.hit_count = 8'd0;
			chm_pkg::OP_IGNORE: begin
				res.cell_index = '0;
				res.ignored    = 1'b1;
			end
			chm_pkg::OP_RECORD: begin
				if (rdata_s1 == chm_pkg::COUNT_MAX) begin
					res.hit_count     = rdata_s1;
					res.was_saturated = 1'b1;
				end else begin
					res.hit_count = rdata_s1 + 8'd1;
				end
			end
			default: res = '0;
		endcase
		mem_we   = 1'b0;
		mem_wd   = res.hit_count;
		mem_addr = AW'(op_data.addr);
		case (state_q)
			chm_pkg::BK_CLEAR: begin
				mem_we   = 1'b1;
				mem_wd   = 8'd0;
				mem_addr = clr_q;
			end
			chm_pkg::BK_EXEC: begin
				mem_addr = AW'(op_s1.addr);
				mem_we   = (op_s1.kind == chm_pkg::OP_RECORD) && !res.was_saturated;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chm_pkg::BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == chm_pkg::BK_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == chm_pkg::BK_EXEC) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wd;
		end
		rdata_s1 <= mem[mem_addr];
		if (op_valid && op_ready) begin
			op_s1 <= op_data;
		end
		if (state_q == chm_pkg::BK_EXEC) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/coverage_hitcount_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage hit-count map
// Table of 8-bit saturating edge hit counters with record and read commands.
// ----------------------------------------------------------------------------
// Usage:
// Input words (in_valid/in_ready) carry a command. A record word reduces its
// 64-bit edge id to a cell, edge_id modulo (map_pages * PAGE_BYTES), and
// bumps that counter unless it already holds 255. A read word returns the
// counter at read_index, or 0 beyond the table. Every word yields exactly one
// output word (out_valid/out_ready), in order.
// A read or a disabled record passes the front-end entry register, the queue,
// the back-end read stage and the output register; an enabled record first
// runs the bit-serial remainder unit in the front end (one edge bit per cycle,
// 64 bits). The front end takes one word at a time and accepts no new word
// until the last one is pushed into the queue. The counter memory has a
// single port and spends an IDLE and an EXEC state on each operation.
// Configuration words (cfg_valid/cfg_ready) are always taken: index 0 sets
// map_enabled, index 1 sets map_pages; other indexes are dropped. Write them
// only while the block is idle.
// Reset: after arst_n releases, the back end clears all MAX_PAGES * PAGE_BYTES
// cells, one per cycle; in_ready stays low until then. A stalled receiver
// holds the output register; the two-entry queue then fills, and the front
// end stops accepting.
// ----------------------------------------------------------------------------
`include "coverage_hitcount_map_assert.svh"

module coverage_hitcount_map #(
	parameter int MAX_PAGES  = 16,
	parameter int PAGE_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  chm_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output chm_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data
);
	localparam int TABLE_CELLS = MAX_PAGES * PAGE_BYTES;

	// Live configuration; the table itself is never touched by these.
	logic         map_enabled_q;
	logic [4:0]   map_pages_q;

	// Handshake between front end, queue and back end.
	logic         init_done;
	logic         push_valid;
	logic         push_ready;
	chm_pkg::op_t push_data;
	logic         pop_valid;
	logic         pop_ready;
	chm_pkg::op_t pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_enabled_q <= 1'b0;
			map_pages_q   <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				chm_pkg::CFG_MAP_ENABLED: map_enabled_q <= cfg_data[0];
				chm_pkg::CFG_MAP_PAGES:   map_pages_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: classify each word and compute the record cell.
	chm_front #(
		.MAX_PAGES   (MAX_PAGES),
		.PAGE_BYTES  (PAGE_BYTES),
		.TABLE_CELLS (TABLE_CELLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.map_enabled (map_enabled_q),
		.map_pages   (map_pages_q),
		.init_done   (init_done),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// Short queue so that a stalled receiver does not stall a running divide.
	chm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	// Back end: counter memory, clearing sweep and output register.
	chm_back #(
		.TABLE_CELLS (TABLE_CELLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (pop_valid),
		.op_ready  (pop_ready),
		.op_data   (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.init_done (init_done)
	);

	// No word may enter while the counter table is still being cleared.
	`CHM_ASSERT_NOW(a_no_accept_during_clear, in_ready, init_done)

	// A dropped record reports nothing but the ignored flag.
	`CHM_ASSERT_NOW(a_ignored_clean, out_valid && out_data.ignored,
		out_data.hit_count == 8'd0 && out_data.cell_index == 16'd0 && !out_data.was_saturated)

	// A saturated record always reports the ceiling value.
	`CHM_ASSERT_NOW(a_saturated_value, out_valid && out_data.was_saturated,
		out_data.hit_count == chm_pkg::COUNT_MAX && !out_data.ignored)

	// An operation taken by the back end keeps it busy in the following cycle.
	`CHM_ASSERT_NEXT(a_pop_then_busy, pop_valid && pop_ready, !pop_ready)

endmodule

[dv/coverage_hitcount_map_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coverage hit-count map testbench
// Drives record and read words through the hit-count map, keeps its own copy
// of the counter table and both registers, and compares every output word
// against the expected word, field by field and in order.
// ----------------------------------------------------------------------------
module coverage_hitcount_map_tb;

	localparam int CELLS        = 16 * 4096;
	localparam int MAX_PG       = 16;
	localparam int IDLE_LIMIT   = 200000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	chm_pkg::in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	chm_pkg::out_word_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	// Shadow of the block: counter table and both registers.
	logic [7:0] shadow_counts [CELLS];
	logic       shadow_enabled;
	logic [4:0] shadow_pages;

	chm_pkg::out_word_t expected_words [$];
	int         error_count = 0;
	int         quiet_cycles = 0;
	// Receiver stall pattern: a mask walked one bit per cycle, set per phase.
	logic [15:0] stall_mask = 16'h0000;
	logic [3:0]  stall_pos = 4'd0;

	coverage_hitcount_map dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Live map size in cells, with zero pages treated as one and large values
	// clamped to the table.
	function automatic int live_cells();
		int pages;
		pages = shadow_pages;
		if (pages == 0) begin
			pages = 1;
		end
		if (pages > MAX_PG) begin
			pages = MAX_PG;
		end
		return pages * 4096;
	endfunction

	// Work out the output word for one accepted input word and update the
	// shadow table the same way the block does.
	function automatic chm_pkg::out_word_t predict_hit(input chm_pkg::in_word_t w);
		chm_pkg::out_word_t r;
		int        slot;
		r = '0;
		if (w.cmd == chm_pkg::CMD_READ) begin
			r.cell_index = w.read_index;
			if (int'(w.read_index) < CELLS) begin
				r.hit_count = shadow_counts[w.read_index];
			end
		end else if (!shadow_enabled) begin
			r.ignored = 1'b1;
		end else begin
			slot = int'(w.edge_id % 64'(live_cells()));
			if (shadow_counts[slot] == chm_pkg::COUNT_MAX) begin
				r.was_saturated = 1'b1;
			end else begin
				shadow_counts[slot] = shadow_counts[slot] + 8'd1;
			end
			r.cell_index = slot[15:0];
			r.hit_count = shadow_counts[slot];
		end
		return r;
	endfunction

	// Output side: stall on the mask, check each accepted word.
	always @(posedge clk) begin
		chm_pkg::out_word_t want;
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 64'(out_data), 64'd0);
			end else begin
				want = expected_words.pop_front();
				if (out_data.cell_index !== want.cell_index)
					report_mismatch("cell_index", 64'(out_data.cell_index),
						64'(want.cell_index));
				if (out_data.hit_count !== want.hit_count)
					report_mismatch("hit_count", 64'(out_data.hit_count),
						64'(want.hit_count));
				if (out_data.was_saturated !== want.was_saturated)
					report_mismatch("was_saturated", 64'(out_data.was_saturated),
						64'(want.was_saturated));
				if (out_data.ignored !== want.ignored)
					report_mismatch("ignored", 64'(out_data.ignored),
						64'(want.ignored));
			end
		end
	end

	always @(negedge clk) begin
		stall_pos <= stall_pos + 4'd1;
		out_ready <= !stall_mask[stall_pos];
	end

	// Watchdog: counts cycles with no word moving on any channel. The reset
	// clearing pass alone stays well inside the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("coverage_hitcount_map: mismatch");
				$finish;
			end
		end
	end

	// Send one word; the expectation is formed when the word is accepted.
	task automatic send_word(input chm_pkg::in_word_t w);
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		expected_words.push_back(predict_hit(w));
		@(negedge clk);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic send_record(input logic [63:0] edge_v);
		chm_pkg::in_word_t w;
		w = '0;
		w.cmd = chm_pkg::CMD_RECORD;
		w.edge_id = edge_v;
		w.read_index = 16'($urandom);
		send_word(w);
	endtask

	task automatic send_read(input logic [15:0] idx);
		chm_pkg::in_word_t w;
		w = '0;
		w.cmd = chm_pkg::CMD_READ;
		w.edge_id = {$urandom, $urandom};
		w.read_index = idx;
		send_word(w);
	endtask

	// Wait until every expected word is back, then let the slowest record
	// finish in the pipeline before touching anything else.
	task automatic wait_drained();
		drop_valid();
		while (expected_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == chm_pkg::CFG_MAP_ENABLED) begin
			shadow_enabled = val[0];
		end else if (idx == chm_pkg::CFG_MAP_PAGES) begin
			shadow_pages = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic en, input logic [4:0] pages);
		wait_drained();
		write_reg(chm_pkg::CFG_MAP_ENABLED, 5'(en));
		write_reg(chm_pkg::CFG_MAP_PAGES, pages);
	endtask

	// Disabled records are dropped, reads still work, and defaults apply.
	task automatic test_disabled();
		send_record('1);
		send_record(64'd0);
		send_read(16'd0);
		send_read(16'hffff);
		// An unknown register index must change nothing.
		wait_drained();
		write_reg(2'd3, 5'h1f);
		write_reg(2'd2, 5'h00);
		send_record(64'd5);
	endtask

	// Field extremes, saturation and the wrap at each page-count edge case.
	task automatic test_directed();
		configure(1'b1, 5'd0);
		send_record(64'd0);
		send_record('1);
		send_record(64'd4096);
		send_read(16'd0);
		send_read(16'd4095);
		// Drive one cell past 255 so the count saturates.
		for (int i = 0; i < 258; i++) begin
			send_record(64'd7 + 64'd4096 * 64'(i));
		end
		send_read(16'd7);
		configure(1'b1, 5'd31);
		send_record('1);
		send_record(64'h8000_0000_0000_0000);
		send_read(16'hffff);
		configure(1'b1, 5'd16);
		send_record(64'd65535);
		send_read(16'd65535);
		configure(1'b1, 5'd3);
		send_read(16'd60000);
		send_record(64'd12288);
	endtask

	// Random traffic in bursts with gaps; most words are records, most of them landing
	// on a small cell set so counts build up, the rest reads of random or low cells.
	task automatic test_random(input int count, input logic [4:0] pages);
		int burst;
		int sent;
		int gap;
		logic [63:0] e;
		configure(1'b1, pages);
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < count; i++) begin
				case ($urandom_range(0, 9))
					0, 1: send_read(16'($urandom));
					2: send_read(16'($urandom_range(0, 31)));
					3: begin
						e = {$urandom, $urandom};
						send_record(e);
					end
					default: begin
						e = {$urandom, $urandom};
						e[11:0] = 12'($urandom_range(0, 31));
						send_record(e);
					end
				endcase
				sent++;
			end
			gap = $urandom_range(0, 4) * int'($urandom_range(0, 3) == 0);
			if (gap > 0) begin
				drop_valid();
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			shadow_counts[i] = 8'd0;
		end
		shadow_enabled = 1'b0;
		shadow_pages = 5'd1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_disabled();
		test_directed();
		stall_mask = 16'h0000;
		test_random(225, 5'd1);
		stall_mask = 16'h9248;
		test_random(225, 5'd16);
		stall_mask = 16'hf0f1;
		test_random(225, 5'd5);
		stall_mask = 16'h0101;
		test_random(225, 5'd0);
		// Disable again: records must be dropped, earlier counts kept.
		configure(1'b0, 5'd2);
		for (int i = 0; i < 20; i++) begin
			send_record({$urandom, $urandom});
			send_read(16'($urandom_range(0, 31)));
		end

		wait_drained();
		if (error_count == 0) begin
			$display("coverage_hitcount_map: match");
		end else begin
			$display("coverage_hitcount_map: mismatch");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/chm_pkg.sv
hw/rtl/chm_front.sv
hw/rtl/chm_queue.sv
hw/rtl/chm_back.sv
hw/rtl/coverage_hitcount_map.sv
dv/coverage_hitcount_map_tb.sv
